// File: src/tct_pkg.sv
package tct_pkg;

   // screen geometry defaults
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // item field widths
   localparam int OP_W    = 2;
   localparam int CODE_W  = 8;
   localparam int INDEX_W = 11;
   localparam int POS_W   = 11;
   localparam int ATTR_W  = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // control characters and attribute reset
   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CODE_W-1:0] CODE_BLANK     = 8'd0;
   localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h0f;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_CHAR,
      CMD_NEWLINE,
      CMD_BACKSPACE,
      CMD_CLEAR,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [CODE_W-1:0]   code;
      logic [INDEX_W-1:0]  index;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_CLEAR,
      BK_SCROLL,
      BK_FILL,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

// File: src/tct_req_if.sv
interface tct_req_if;
   logic                        valid;
   logic                        ready;
   logic [tct_pkg::OP_W-1:0]    operation;
   logic [tct_pkg::CODE_W-1:0]  char_code;
   logic [tct_pkg::INDEX_W-1:0] cell_index;

   modport source (output valid, output operation, output char_code, output cell_index,
                   input ready);
   modport sink (input valid, input operation, input char_code, input cell_index,
                 output ready);
endinterface

// File: src/tct_rsp_if.sv
interface tct_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tct_pkg::POS_W-1:0]  cursor_position;
   logic [tct_pkg::CODE_W-1:0] read_char;
   logic [tct_pkg::ATTR_W-1:0] read_attr;

   modport source (output valid, output cursor_position, output read_char, output read_attr,
                   input ready);
   modport sink (input valid, input cursor_position, input read_char, input read_attr,
                 output ready);
endinterface

// File: src/tct_front.sv
module tct_front #(
   parameter int COLUMNS = tct_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tct_pkg::ROWS_DEFAULT
) (
   tct_req_if.sink                 req,
   input  tct_pkg::back_status_type status,
   input  logic                    q_full,
   output logic                    q_push,
   output tct_pkg::cmd_type        q_cmd
);

   localparam int CELL_COUNT = COLUMNS * ROWS;

   // take items while the queue has room and the power-up clear is done
   assign req.ready = !q_full && !status.init_busy;
   assign q_push    = req.valid && req.ready;

   // classify the item into a back-end command
   always_comb begin
      q_cmd.code  = req.char_code;
      q_cmd.index = req.cell_index;
      case (req.operation)
         tct_pkg::OP_PUT: begin
            if (req.char_code == tct_pkg::CODE_NEWLINE) begin
               q_cmd.kind = tct_pkg::CMD_NEWLINE;
            end else if (req.char_code == tct_pkg::CODE_BACKSPACE) begin
               q_cmd.kind = tct_pkg::CMD_BACKSPACE;
            end else begin
               q_cmd.kind = tct_pkg::CMD_CHAR;
            end
         end
         tct_pkg::OP_CLEAR: begin
            q_cmd.kind = tct_pkg::CMD_CLEAR;
         end
         tct_pkg::OP_READ: begin
            // a read past the store answers zeros
            if (32'(req.cell_index) < 32'(CELL_COUNT)) begin
               q_cmd.kind = tct_pkg::CMD_READ;
            end else begin
               q_cmd.kind = tct_pkg::CMD_NOP;
            end
         end
         default: begin
            q_cmd.kind = tct_pkg::CMD_NOP;
         end
      endcase
   end

endmodule

// File: src/tct_cmd_queue.sv
module tct_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tct_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output tct_pkg::cmd_type pop_cmd,
   output logic             not_empty
);

   tct_pkg::cmd_type                  entries_ff [tct_pkg::QUEUE_DEPTH];
   logic [tct_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tct_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tct_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   localparam logic [tct_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      tct_pkg::QUEUE_PTR_W'(tct_pkg::QUEUE_DEPTH - 1);
   localparam logic [tct_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
      tct_pkg::QUEUE_CNT_W'(tct_pkg::QUEUE_DEPTH);

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/tct_back.sv
module tct_back #(
   parameter int COLUMNS = tct_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tct_pkg::ROWS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tct_pkg::ATTR_W-1:0]   text_attribute,
   input  logic                         q_valid,
   input  tct_pkg::cmd_type             q_cmd,
   output logic                         q_pop,
   output tct_pkg::back_status_type     status,
   tct_rsp_if.source                    rsp
);

   localparam int CELL_COUNT    = COLUMNS * ROWS;
   localparam int AW            = $clog2(CELL_COUNT);
   localparam int CW            = $clog2(COLUMNS);
   localparam int RW            = $clog2(ROWS);
   localparam int CELL_W        = tct_pkg::ATTR_W + tct_pkg::CODE_W;
   localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

   tct_pkg::back_state_type       state_ff, state_in;
   logic [CW-1:0]                 col_ff, col_in;
   logic [RW-1:0]                 row_ff, row_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [AW-1:0]                 sweep_ff, sweep_in;
   logic                          wr_pend_ff, wr_pend_in;
   logic [AW-1:0]                 wr_addr_ff, wr_addr_in;
   logic                          read_ff, read_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tct_pkg::POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [tct_pkg::CODE_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [tct_pkg::ATTR_W-1:0]    rsp_attr_ff, rsp_attr_in;

   logic [CELL_W-1:0]             screen_ff [CELL_COUNT];
   logic [CELL_W-1:0]             mem_rdata_ff;
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [CELL_W-1:0]             mem_wdata;
   logic [AW-1:0]                 mem_raddr;
   logic                          slot_free;

   assign slot_free           = !rsp_valid_ff || rsp.ready;
   assign status.init_busy    = (state_ff == tct_pkg::BK_INIT);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.cursor_position = rsp_pos_ff;
   assign rsp.read_char       = rsp_char_ff;
   assign rsp.read_attr       = rsp_attr_ff;

   // sequencer: next state, cursor update and cell store port
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pos_in       = pos_ff;
      sweep_in     = sweep_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      read_in      = read_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = '0;
      mem_raddr    = sweep_ff;
      q_pop        = 1'b0;
      case (state_ff)
         tct_pkg::BK_INIT, tct_pkg::BK_CLEAR: begin
            // zero sweep over the whole store
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = (state_ff == tct_pkg::BK_INIT) ? tct_pkg::BK_IDLE
                                                         : tct_pkg::BK_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         tct_pkg::BK_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop    = 1'b1;
               read_in  = 1'b0;
               state_in = tct_pkg::BK_DONE;
               case (q_cmd.kind)
                  tct_pkg::CMD_CHAR: begin
                     mem_we    = 1'b1;
                     mem_wdata = {text_attribute, q_cmd.code};
                     if (col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           pos_in   = LAST_BASE;
                           sweep_in = '0;
                           state_in = tct_pkg::BK_SCROLL;
                        end else begin
                           row_in = row_ff + 1'b1;
                           pos_in = pos_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                        pos_in = pos_ff + 1'b1;
                     end
                  end
                  tct_pkg::CMD_NEWLINE: begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        pos_in   = LAST_BASE;
                        sweep_in = '0;
                        state_in = tct_pkg::BK_SCROLL;
                     end else begin
                        row_in = row_ff + 1'b1;
                        pos_in = pos_ff - AW'(col_ff) + COLS_A;
                     end
                  end
                  tct_pkg::CMD_BACKSPACE: begin
                     // column 0 leaves everything as it is
                     if (col_ff != '0) begin
                        col_in    = col_ff - 1'b1;
                        pos_in    = pos_ff - 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = pos_ff - 1'b1;
                        mem_wdata = {text_attribute, tct_pkg::CODE_BLANK};
                     end
                  end
                  tct_pkg::CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     pos_in   = '0;
                     sweep_in = '0;
                     state_in = tct_pkg::BK_CLEAR;
                  end
                  tct_pkg::CMD_READ: begin
                     read_in   = 1'b1;
                     mem_raddr = AW'(q_cmd.index);
                  end
                  default: begin
                     read_in = 1'b0;
                  end
               endcase
            end
         end
         tct_pkg::BK_SCROLL: begin
            // copy each cell one row up, read and write overlapped
            if (wr_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = mem_rdata_ff;
            end
            if (sweep_ff != LAST_BASE) begin
               mem_raddr  = sweep_ff + COLS_A;
               wr_pend_in = 1'b1;
               wr_addr_in = sweep_ff;
               sweep_in   = sweep_ff + 1'b1;
            end else begin
               state_in = tct_pkg::BK_FILL;
            end
         end
         tct_pkg::BK_FILL: begin
            // blank the new bottom row with the current attribute
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = {text_attribute, tct_pkg::CODE_BLANK};
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = tct_pkg::BK_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         tct_pkg::BK_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = tct_pkg::POS_W'(pos_ff);
            rsp_char_in  = read_ff ? mem_rdata_ff[tct_pkg::CODE_W-1:0] : '0;
            rsp_attr_in  = read_ff ? mem_rdata_ff[CELL_W-1:tct_pkg::CODE_W] : '0;
            state_in     = tct_pkg::BK_IDLE;
         end
         default: begin
            state_in = tct_pkg::BK_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tct_pkg::BK_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         pos_ff       <= '0;
         sweep_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         read_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pos_ff       <= pos_in;
         sweep_ff     <= sweep_in;
         wr_pend_ff   <= wr_pend_in;
         read_ff      <= read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   // cell store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= screen_ff[mem_raddr];
   end

   // cursor stays on the screen
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= LAST_COL)
      else $error("cursor column past last column");

   // linear position tracks row and column
   a_pos_linear: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) == 32'(row_ff) * 32'(COLUMNS) + 32'(col_ff))
      else $error("linear cursor position out of step");

   // scrolling only happens with the cursor at the start of the last row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      state_ff == tct_pkg::BK_SCROLL |-> (row_ff == LAST_ROW && col_ff == '0))
      else $error("scroll with cursor off the last row start");

   // a result is only produced into a free output register
   a_done_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == tct_pkg::BK_DONE |-> !rsp_valid_ff)
      else $error("result overwrites one not yet taken");

   // results come only from the done step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tct_pkg::BK_DONE))
      else $error("result raised outside done step");

endmodule

// File: src/text_console_teletype.sv
// Text-mode teletype console with a ROWS x COLUMNS character/attribute store.
// Items enter on req_chan (operation, char_code, cell_index) and each gives
// exactly one item on rsp_chan (cursor_position, read_char, read_attr); both
// use a valid/ready handshake, accepted when valid and ready are high.
// The attribute register sits at byte addresses 0 to 3 of the APB-style port
// and is written with psel, penable and pwrite high; change it only while idle.
// A front stage classifies items into a two-entry command queue, so two items
// can be taken while the back end is busy or the output is stalled.
// The back end runs one command at a time against a cell memory with one write
// port and one registered read port: characters, newlines, backspaces and reads
// pass from the queue head through the done step into the result register, and
// the next command is taken only once the back end is idle again; a scroll
// copies each cell one row up, one cell copy per cycle, then fills the last row
// with blanks; clear sweeps the whole store to zero. After reset the store is
// swept to zero, during which req_chan.ready stays low; the cursor and attribute
// (0x0f) reset at once. When rsp_chan is stalled the result holds in its
// register, the back end waits, and req_chan.ready drops once the queue is full.
module text_console_teletype #(
   parameter int COLUMNS = tct_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tct_pkg::ROWS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   tct_req_if.sink                          req_chan,
   tct_rsp_if.source                        rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tct_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tct_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   logic [tct_pkg::ATTR_W-1:0]   attr_ff, attr_in;
   logic                         attr_sel;
   tct_pkg::back_status_type     status;
   tct_pkg::cmd_type             push_cmd;
   tct_pkg::cmd_type             pop_cmd;
   logic                         q_push;
   logic                         q_pop;
   logic                         q_full;
   logic                         q_not_empty;

   // register port
   assign pready   = 1'b1;
   assign attr_sel = (paddr[tct_pkg::CSR_ADDR_W-1] == tct_pkg::REG_TEXT_ATTRIBUTE);
   assign prdata   = attr_sel ? tct_pkg::CSR_DATA_W'(attr_ff) : '0;

   always_comb begin
      attr_in = attr_ff;
      if (psel && penable && pwrite && pready && attr_sel) begin
         attr_in = pwdata[tct_pkg::ATTR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tct_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // item classification
   tct_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req    (req_chan),
      .status (status),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   // command queue
   tct_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_cmd   (pop_cmd),
      .not_empty (q_not_empty)
   );

   // command execution and cell store
   tct_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .text_attribute (attr_ff),
      .q_valid        (q_not_empty),
      .q_cmd          (pop_cmd),
      .q_pop          (q_pop),
      .status         (status),
      .rsp            (rsp_chan)
   );

endmodule
